@@ design/tak_pkg.sv @@
// Shared widths and transfer types for the tilt angle Kalman filter.
package tak_pkg;

    localparam int FRAC      = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MEAS_W    = 24;
    localparam int GYRO_W    = 28;
    localparam int ANG_W     = 32;
    localparam int COV_W     = 40;
    localparam int GAIN_W    = 32;
    localparam int ERR_W     = ANG_W + 1;
    localparam int DEN_W     = COV_W + 1;
    localparam int MUL_A_W   = COV_W + 2;
    localparam int MUL_B_W   = CFG_W + 1;
    localparam int MUL_P_W   = 52;
    localparam int MUL_DIG_W = 11;
    localparam int MUL_NDIG  = (MUL_B_W + MUL_DIG_W - 1) / MUL_DIG_W;
    localparam int MUL_BD_W  = MUL_NDIG * MUL_DIG_W;
    localparam int SUM_W     = MUL_P_W + 2;

    typedef struct packed {
        logic signed [MEAS_W-1:0] angle_measured;
        logic signed [GYRO_W-1:0] gyro_rate;
    } t_in_item;

    typedef struct packed {
        logic signed [ANG_W-1:0] angle_estimate;
        logic signed [ANG_W-1:0] rate_estimate;
    } t_out_item;

endpackage

@@ design/tilt_angle_kalman_filter.sv @@
// Two-state angle/gyro-bias Kalman filter, sequenced over a shared multiplier and divider.
//
//  channel  dir  handshake                  payload
//  -------  ---  -------------------------  -----------------------------------------
//  input    in   i_in_valid / o_in_stall    i_in_data  (angle_measured, gyro_rate)
//  output   out  o_out_valid / i_out_stall  o_out_data (angle_estimate, rate_estimate)
//  config   in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  An item runs ten multiplies on the shared digit-serial multiplier and two gains
//  on the bit-serial divider, one at a time; a saturated gain or a zero denominator
//  ends its division early.
//  o_in_stall is high from the input transfer until the result is loaded.
//  The result register lets the next item in while the last result waits.
//  Reset is synchronous: control, config and estimate registers go to their defaults, covariance to identity.
module tilt_angle_kalman_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tak_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tak_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tak_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tak_pkg::t_out_item                o_out_data
);
    import tak_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_NOISE = 2'd0,
        CFG_BIAS_NOISE  = 2'd1,
        CFG_MEAS_NOISE  = 2'd2,
        CFG_TIME_STEP   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_M_RATE, S_M_D0, S_M_D12, S_M_BQ, S_D_K0, S_D_K1,
        S_C_00, S_C_01, S_C_10, S_C_11, S_C_ANG, S_C_BIAS, S_OUT
    } t_state;

    localparam logic [CFG_W-1:0] RST_ANGLE_NOISE = CFG_W'(16777);
    localparam logic [CFG_W-1:0] RST_BIAS_NOISE  = CFG_W'(50332);
    localparam logic [CFG_W-1:0] RST_MEAS_NOISE  = CFG_W'(8388608);
    localparam logic [CFG_W-1:0] RST_TIME_STEP   = CFG_W'(33554);
    localparam logic signed [COV_W-1:0] P_ONE    = COV_W'(1) << FRAC;

    localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] S32_MIN = SUM_W'(-64'sd2147483648);
    localparam logic signed [SUM_W-1:0] S40_MAX = SUM_W'(64'sd549755813887);
    localparam logic signed [SUM_W-1:0] S40_MIN = SUM_W'(-64'sd549755813888);

    function automatic logic signed [ANG_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        priority if (v > S32_MAX) r = {1'b0, {(ANG_W-1){1'b1}}};
        else if (v < S32_MIN)     r = {1'b1, {(ANG_W-1){1'b0}}};
        else                      r = v[ANG_W-1:0];
        return r;
    endfunction

    function automatic logic signed [COV_W-1:0] sat40(input logic signed [SUM_W-1:0] v);
        logic signed [COV_W-1:0] r;
        priority if (v > S40_MAX) r = {1'b0, {(COV_W-1){1'b1}}};
        else if (v < S40_MIN)     r = {1'b1, {(COV_W-1){1'b0}}};
        else                      r = v[COV_W-1:0];
        return r;
    endfunction

    t_state                      r_state;
    logic                        r_issued;
    logic [CFG_W-1:0]            r_apn;
    logic [CFG_W-1:0]            r_bpn;
    logic [CFG_W-1:0]            r_mn;
    logic [CFG_W-1:0]            r_dt;
    t_in_item                    r_in;
    logic signed [ANG_W-1:0]     r_angle;
    logic signed [ANG_W-1:0]     r_bias;
    logic signed [COV_W-1:0]     r_p00;
    logic signed [COV_W-1:0]     r_p01;
    logic signed [COV_W-1:0]     r_p10;
    logic signed [COV_W-1:0]     r_p11;
    logic signed [COV_W-1:0]     r_t0;
    logic signed [COV_W-1:0]     r_t1;
    logic signed [ERR_W-1:0]     r_err;
    logic signed [GAIN_W-1:0]    r_k0;
    logic signed [GAIN_W-1:0]    r_k1;
    logic                        r_out_valid;
    t_out_item                   r_out;

    t_state                      w_next;
    logic                        w_is_div;
    logic                        w_is_cov_fix;
    logic                        w_mul_start;
    logic                        w_div_start;
    logic                        w_mul_done;
    logic                        w_div_done;
    logic                        w_unit_done;
    logic signed [MUL_A_W-1:0]   w_a;
    logic signed [MUL_B_W-1:0]   w_b;
    logic signed [MUL_P_W-1:0]   w_mul_p;
    logic signed [GAIN_W-1:0]    w_gain;
    logic signed [COV_W-1:0]     w_num;
    logic signed [DEN_W-1:0]     w_den;
    logic signed [ANG_W-1:0]     w_rate;
    logic signed [MUL_A_W-1:0]   w_d0;
    logic signed [MUL_B_W-1:0]   w_dt;
    logic signed [SUM_W-1:0]     w_base;
    logic signed [SUM_W-1:0]     w_addend;
    logic signed [SUM_W-1:0]     w_sum;
    logic signed [SUM_W-1:0]     w_sum10;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_is_div     = (r_state == S_D_K0) || (r_state == S_D_K1);
    assign w_is_cov_fix = (r_state == S_C_00) || (r_state == S_C_01) ||
                          (r_state == S_C_10) || (r_state == S_C_11);
    assign w_mul_start  = !r_issued && o_in_stall && (r_state != S_OUT) && !w_is_div;
    assign w_div_start  = !r_issued && w_is_div;
    assign w_unit_done  = w_is_div ? w_div_done : w_mul_done;

    assign w_rate = sat32(SUM_W'(r_in.gyro_rate) - SUM_W'(r_bias));
    assign w_d0   = {{(MUL_A_W-CFG_W){1'b0}}, r_apn} - MUL_A_W'(r_p01) - MUL_A_W'(r_p10);
    assign w_dt   = {{(MUL_B_W-CFG_W){1'b0}}, r_dt};
    assign w_num  = (r_state == S_D_K1) ? r_p10 : r_p00;
    assign w_den  = DEN_W'({1'b0, r_mn}) + DEN_W'(r_p00);

    always_comb begin
        unique case (r_state)
            S_M_RATE: begin w_a = MUL_A_W'(w_rate);                        w_b = w_dt;  end
            S_M_D0:   begin w_a = w_d0;                                    w_b = w_dt;  end
            S_M_D12:  begin w_a = -MUL_A_W'(r_p11);                        w_b = w_dt;  end
            S_M_BQ:   begin w_a = {{(MUL_A_W-CFG_W){1'b0}}, r_bpn};        w_b = w_dt;  end
            S_C_00:   begin w_a = MUL_A_W'(r_t0);  w_b = MUL_B_W'(r_k0); end
            S_C_01:   begin w_a = MUL_A_W'(r_t1);  w_b = MUL_B_W'(r_k0); end
            S_C_10:   begin w_a = MUL_A_W'(r_t0);  w_b = MUL_B_W'(r_k1); end
            S_C_11:   begin w_a = MUL_A_W'(r_t1);  w_b = MUL_B_W'(r_k1); end
            S_C_ANG:  begin w_a = MUL_A_W'(r_err); w_b = MUL_B_W'(r_k0); end
            S_C_BIAS: begin w_a = MUL_A_W'(r_err); w_b = MUL_B_W'(r_k1); end
            default:  begin w_a = '0;              w_b = '0;             end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_M_RATE, S_C_ANG: w_base = SUM_W'(r_angle);
            S_C_BIAS:          w_base = SUM_W'(r_bias);
            S_M_D0, S_C_00:    w_base = SUM_W'(r_p00);
            S_M_D12, S_C_01:   w_base = SUM_W'(r_p01);
            S_M_BQ, S_C_11:    w_base = SUM_W'(r_p11);
            default:           w_base = SUM_W'(r_p10);
        endcase
    end

    assign w_addend = w_is_cov_fix ? -SUM_W'(w_mul_p) : SUM_W'(w_mul_p);
    assign w_sum    = w_base + w_addend;
    assign w_sum10  = SUM_W'(r_p10) + w_addend;

    always_comb begin
        unique case (r_state)
            S_M_RATE: w_next = S_M_D0;
            S_M_D0:   w_next = S_M_D12;
            S_M_D12:  w_next = S_M_BQ;
            S_M_BQ:   w_next = S_D_K0;
            S_D_K0:   w_next = S_D_K1;
            S_D_K1:   w_next = S_C_00;
            S_C_00:   w_next = S_C_01;
            S_C_01:   w_next = S_C_10;
            S_C_10:   w_next = S_C_11;
            S_C_11:   w_next = S_C_ANG;
            S_C_ANG:  w_next = S_C_BIAS;
            S_C_BIAS: w_next = S_OUT;
            default:  w_next = S_IDLE;
        endcase
    end

    tak_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    tak_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_gain  (w_gain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_apn       <= RST_ANGLE_NOISE;
            r_bpn       <= RST_BIAS_NOISE;
            r_mn        <= RST_MEAS_NOISE;
            r_dt        <= RST_TIME_STEP;
            r_angle     <= '0;
            r_bias      <= '0;
            r_p00       <= P_ONE;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= P_ONE;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ANGLE_NOISE: r_apn <= i_cfg_data;
                    CFG_BIAS_NOISE:  r_bpn <= i_cfg_data;
                    CFG_MEAS_NOISE:  r_mn  <= i_cfg_data;
                    CFG_TIME_STEP:   r_dt  <= i_cfg_data;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_state <= S_M_RATE;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid          <= 1'b1;
                        r_out.angle_estimate <= r_angle;
                        r_out.rate_estimate  <= w_rate;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                        if (r_state == S_D_K0) begin
                            r_err <= ERR_W'(r_in.angle_measured) - ERR_W'(r_angle);
                            r_t0  <= r_p00;
                            r_t1  <= r_p01;
                        end
                    end else if (w_unit_done) begin
                        r_issued <= 1'b0;
                        r_state  <= w_next;
                        unique case (r_state)
                            S_M_RATE, S_C_ANG: r_angle <= sat32(w_sum);
                            S_C_BIAS:          r_bias  <= sat32(w_sum);
                            S_M_D0, S_C_00:    r_p00   <= sat40(w_sum);
                            S_C_01:            r_p01   <= sat40(w_sum);
                            S_C_10:            r_p10   <= sat40(w_sum10);
                            S_M_D12: begin
                                r_p01 <= sat40(w_sum);
                                r_p10 <= sat40(w_sum10);
                            end
                            S_M_BQ, S_C_11:    r_p11   <= sat40(w_sum);
                            S_D_K0:            r_k0    <= w_gain;
                            S_D_K1:            r_k1    <= w_gain;
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

@@ design/tak_mul.sv @@
// Multi-cycle signed multiplier with Q.24 round-half-up, one 11-bit digit per cycle.
module tak_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tak_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [tak_pkg::MUL_B_W-1:0]  i_b,
    output logic                                o_done,
    output logic signed [tak_pkg::MUL_P_W-1:0]  o_p
);
    import tak_pkg::*;

    localparam int ACC_W = FRAC + MUL_P_W;
    localparam int CNT_W = $clog2(MUL_NDIG);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_NDIG - 1);
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC - 1);

    typedef enum logic [1:0] {M_IDLE, M_ACC, M_RND} t_mstate;

    t_mstate                          r_state;
    logic [CNT_W-1:0]                 r_cnt;
    logic [MUL_A_W-1:0]               r_amag;
    logic [MUL_BD_W-1:0]              r_bmag;
    logic                             r_neg;
    logic signed [ACC_W-1:0]          r_acc;
    logic                             r_done;
    logic signed [MUL_P_W-1:0]        r_p;
    logic [MUL_A_W+MUL_DIG_W-1:0]     w_pp;
    logic signed [ACC_W-1:0]          w_ppx;
    logic signed [ACC_W-1:0]          w_acc_nx;
    logic signed [ACC_W-1:0]          w_rnd;

    assign w_pp     = r_amag * r_bmag[MUL_BD_W-1 -: MUL_DIG_W];
    assign w_ppx    = r_neg ? -ACC_W'(w_pp) : ACC_W'(w_pp);
    assign w_acc_nx = (r_acc <<< MUL_DIG_W) + w_ppx;
    assign w_rnd    = r_acc + RND;
    assign o_done   = r_done;
    assign o_p      = r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_amag  <= i_a[MUL_A_W-1] ? -i_a : i_a;
                        r_bmag  <= MUL_BD_W'($unsigned(i_b[MUL_B_W-1] ? -i_b : i_b));
                        r_neg   <= i_a[MUL_A_W-1] ^ i_b[MUL_B_W-1];
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_ACC;
                    end
                end
                M_ACC: begin
                    r_acc  <= w_acc_nx;
                    r_bmag <= r_bmag << MUL_DIG_W;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= M_RND;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                M_RND: begin
                    r_p     <= w_rnd[ACC_W-1 -: MUL_P_W];
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

endmodule

@@ design/tak_div.sv @@
// Restoring divider for the Q8.24 gain: rounded, signed and saturated, one bit per cycle.
module tak_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [tak_pkg::COV_W-1:0]   i_num,
    input  logic signed [tak_pkg::DEN_W-1:0]   i_den,
    output logic                               o_done,
    output logic signed [tak_pkg::GAIN_W-1:0]  o_gain
);
    import tak_pkg::*;

    localparam int N_W   = COV_W + FRAC + 1;
    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [GAIN_W-1:0] Q_HALF = {1'b1, {(GAIN_W-1){1'b0}}};
    localparam logic signed [GAIN_W-1:0] G_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] G_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_ITER, D_FINAL} t_dstate;

    t_dstate                    r_state;
    logic [CNT_W-1:0]           r_cnt;
    logic [DEN_W-1:0]           r_d;
    logic [DEN_W-1:0]           r_rem;
    logic [GAIN_W-1:0]          r_lo;
    logic [GAIN_W-1:0]          r_q;
    logic                       r_neg;
    logic                       r_sat;
    logic                       r_zero;
    logic                       r_done;
    logic signed [GAIN_W-1:0]   r_gain;
    logic [COV_W-1:0]           w_nmag;
    logic [DEN_W-1:0]           w_dmag;
    logic [N_W-1:0]             w_n;
    logic [DEN_W:0]             w_trial;
    logic [DEN_W:0]             w_diff;
    logic                       w_ge;
    logic signed [GAIN_W-1:0]   w_gain;

    assign w_nmag  = i_num[COV_W-1] ? -i_num : i_num;
    assign w_dmag  = i_den[DEN_W-1] ? -i_den : i_den;
    assign w_n     = {1'b0, w_nmag, {FRAC{1'b0}}} + N_W'(w_dmag >> 1);
    assign w_trial = {r_rem, r_lo[GAIN_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign o_done  = r_done;
    assign o_gain  = r_gain;

    always_comb begin
        priority if (r_zero) begin
            w_gain = '0;
        end else if (r_neg) begin
            w_gain = (r_sat || r_q > Q_HALF) ? G_MIN : $signed(~r_q + 1'b1);
        end else begin
            w_gain = (r_sat || r_q[GAIN_W-1]) ? G_MAX : $signed(r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_d    <= w_dmag;
                        r_rem  <= DEN_W'(w_n[N_W-1:GAIN_W]);
                        r_lo   <= w_n[GAIN_W-1:0];
                        r_q    <= '0;
                        r_neg  <= i_num[COV_W-1] ^ i_den[DEN_W-1];
                        r_sat  <= 1'b0;
                        r_zero <= (i_den == '0);
                        r_cnt  <= CNT_W'(GAIN_W - 1);
                        r_state <= (i_den == '0) ? D_FINAL : D_CHECK;
                    end
                end
                D_CHECK: begin
                    if (r_rem >= r_d) begin
                        r_sat   <= 1'b1;
                        r_state <= D_FINAL;
                    end else begin
                        r_state <= D_ITER;
                    end
                end
                D_ITER: begin
                    r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_q   <= {r_q[GAIN_W-2:0], w_ge};
                    r_lo  <= r_lo << 1;
                    if (r_cnt == '0) begin
                        r_state <= D_FINAL;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                D_FINAL: begin
                    r_gain  <= w_gain;
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

@@ design/tak_chk.sv @@
// Port-level checks for the tilt angle Kalman filter, bound to the top level.
module tak_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input tak_pkg::t_out_item             o_out_data
);
    import tak_pkg::*;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while no item was in work");

    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("block went idle without a result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind tilt_angle_kalman_filter tak_chk u_tak_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
